### rtl/core/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // Sample and config widths
  localparam int SampleW = 32;
  localparam int CfgW    = 9;
  localparam int ApbW    = 32;
  localparam int AddrW   = 3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [CfgW-1:0]           win_len_t;

  // Register word index decoded from paddr
  localparam logic RegWindowLength = 1'b0;

  localparam win_len_t WindowLengthReset = 9'd1;

  // Signed minimum of two samples
  function automatic sample_t smin(input sample_t a, input sample_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### rtl/core/swm_cell.sv
`default_nettype none

// One stage of the running-minimum line: holds the minimum of the last
// (stage index + 1) samples.
module swm_cell import swm_pkg::*; (
  input  wire     clk_i,
  input  wire     shift_i,
  input  sample_t sample_i,
  input  sample_t nbr_i,
  output sample_t run_min_o
);

  sample_t run_min_q;
  sample_t run_min_d;

  // Fold the new word into the neighbor's shorter-window minimum
  always_comb begin
    run_min_d = smin(nbr_i, sample_i);
  end

  // Advance on every accepted word
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      run_min_q <= run_min_d;
    end
  end

  assign run_min_o = run_min_q;

endmodule

`default_nettype wire

### rtl/core/swm_regs.sv
`default_nettype none

// Configuration register file: window_length at byte address 0.
module swm_regs import swm_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire [AddrW-1:0] paddr,
  input  wire [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0] prdata,
  output logic            pready,
  output win_len_t        window_length_o
);

  win_len_t win_len_q;
  win_len_t win_len_d;
  logic     wr_en;
  logic     reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[AddrW-1] == RegWindowLength);
  assign wr_en   = psel & penable & pwrite & pready & reg_hit;

  // Take the low bits of the written word
  always_comb begin
    win_len_d = win_len_q;
    if (wr_en) begin
      win_len_d = pwdata[CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WindowLengthReset;
    end else begin
      win_len_q <= win_len_d;
    end
  end

  // Read back the register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(ApbW-CfgW){1'b0}}, win_len_q};
    end
  end

  assign window_length_o = win_len_q;

endmodule

`default_nettype wire

### rtl/core/sliding_window_minimum.sv
`default_nettype none

// Each accepted s_axis word gives its m_axis word in the next cycle.
// Throughput: one word per cycle unless m_axis stalls; all stages of the
// running-minimum line update together; the output frees as it is taken.
// Reset: clears the live-sample count and the output valid and sets
// window_length to 1; the stages of the line keep their contents.
module sliding_window_minimum import swm_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             s_axis_tvalid,
  output logic            s_axis_tready,
  input  sample_t         s_axis_tdata,   // [31:0] sample
  output logic            m_axis_tvalid,
  input  wire             m_axis_tready,
  output sample_t         m_axis_tdata,   // [31:0] window_min
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire [AddrW-1:0] paddr,
  input  wire [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0] prdata,
  output logic            pready
);

  localparam int CntW = $clog2(WINDOW_MAX + 1);
  localparam int ExtW = (CntW > CfgW) ? CntW : CfgW;
  localparam int IdxW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  win_len_t            window_length;
  logic                accept;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     count_d;
  logic                out_valid_q;
  logic                out_valid_d;
  sample_t             out_data_q;
  sample_t             out_data_d;
  logic [ExtW-1:0]     len_ext;
  logic [ExtW-1:0]     eff_len;
  logic [ExtW-1:0]     keep_lim;
  logic [ExtW-1:0]     cnt_ext;
  logic [ExtW-1:0]     kept;
  logic [IdxW-1:0]     tap_idx;
  sample_t             cell_val [WINDOW_MAX];

  swm_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .window_length_o (window_length)
  );

  // Running-minimum line: stage g holds the minimum of the last g+1 words
  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    sample_t nbr;
    if (g == 0) begin : g_head
      assign nbr = s_axis_tdata;
    end else begin : g_body
      assign nbr = cell_val[g-1];
    end
    swm_cell u_cell (
      .clk_i,
      .shift_i   (accept),
      .sample_i  (s_axis_tdata),
      .nbr_i     (nbr),
      .run_min_o (cell_val[g])
    );
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Clamp the window length into 1..WINDOW_MAX
  always_comb begin
    len_ext = ExtW'(window_length);
    if (len_ext == '0) begin
      eff_len = ExtW'(1);
    end else if (len_ext > ExtW'(WINDOW_MAX)) begin
      eff_len = ExtW'(WINDOW_MAX);
    end else begin
      eff_len = len_ext;
    end
  end

  // Drop samples past the window, then count the new one
  always_comb begin
    keep_lim = eff_len - ExtW'(1);
    cnt_ext  = ExtW'(count_q);
    kept     = (cnt_ext < keep_lim) ? cnt_ext : keep_lim;
    tap_idx  = IdxW'(kept - ExtW'(1));
  end

  // Minimum over the kept words plus the new one
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      count_d     = CntW'(kept + ExtW'(1));
      out_valid_d = 1'b1;
      if (kept == '0) begin
        out_data_d = s_axis_tdata;
      end else begin
        out_data_d = smin(cell_val[tap_idx], s_axis_tdata);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### tb/sv/swm_min_checker.sv
`timescale 1ns / 100ps

// Watch the sample, result and register channels, keep a sorted window of
// live samples and compare every taken result word with its prediction.
module swm_min_checker import swm_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             s_tvalid,
  input  wire             s_tready,
  input  sample_t         s_tdata,   // [31:0] sample
  input  wire             m_tvalid,
  input  wire             m_tready,
  input  sample_t         m_tdata,   // [31:0] window_min
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire [AddrW-1:0] paddr,
  input  wire [ApbW-1:0]  pwdata,
  input  wire             pready,
  output int              fail_count,
  output int              pending
);

  // Live samples in ascending order, each with its age (0 = newest)
  sample_t  live_val [WINDOW_MAX];
  int       live_age [WINDOW_MAX];
  int       live_n;
  win_len_t win_len;
  sample_t  expected_min_q[$];
  sample_t  want;

  // Age the window, drop what leaves it, insert the new sample in order
  function automatic sample_t slide_window(input sample_t s);
    int span;
    int kept;
    int pos;
    span = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : int'(win_len));
    kept = 0;
    for (int i = 0; i < live_n; i++) begin
      if (live_age[i] + 1 < span) begin
        live_val[kept] = live_val[i];
        live_age[kept] = live_age[i] + 1;
        kept++;
      end
    end
    // new sample goes ahead of older equal entries
    pos = 0;
    while (pos < kept && live_val[pos] < s) pos++;
    for (int i = kept; i > pos; i--) begin
      live_val[i] = live_val[i-1];
      live_age[i] = live_age[i-1];
    end
    live_val[pos] = s;
    live_age[pos] = 0;
    live_n = kept + 1;
    return live_val[0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len = WindowLengthReset;
      live_n  = 0;
      expected_min_q.delete();
      pending = 0;
    end else begin
      // match each taken result word against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_min_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected window_min word, expected none, got %0d",
                   $time, m_tdata);
        end else begin
          want = expected_min_q.pop_front();
          if (m_tdata !== want) begin
            fail_count++;
            $display("%0t: window_min mismatch, expected %0d, got %0d",
                     $time, want, m_tdata);
          end
        end
      end
      // track writes to the window length register
      if (psel && penable && pwrite && pready && paddr[AddrW-1:2] == RegWindowLength)
        win_len = win_len_t'(pwdata);
      // predict the minimum for each sample word taken in
      if (s_tvalid && s_tready)
        expected_min_q.push_back(slide_window(s_tdata));
      pending = expected_min_q.size();
    end
  end

endmodule

### tb/sv/tb_sliding_window_minimum.sv
`timescale 1ns / 100ps

module tb_sliding_window_minimum;
  import swm_pkg::*;

  localparam int      NumPhases      = 12;
  localparam int      LongHoldCycles = 300;
  localparam int      DrainCycles    = 4;
  localparam sample_t MaxSample      = 32'sh7fff_ffff;
  localparam sample_t MinSample      = 32'sh8000_0000;

  localparam logic [AddrW-1:0] WinLenAddr   = {RegWindowLength, 2'b00};
  localparam logic [AddrW-1:0] SpareRegAddr = {~RegWindowLength, 2'b00};

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  wire             s_axis_tready;
  sample_t         s_axis_tdata  = '0;   // [31:0] sample
  wire             m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  sample_t         m_axis_tdata;         // [31:0] window_min
  logic            psel          = 1'b0;
  logic            penable       = 1'b0;
  logic            pwrite        = 1'b0;
  logic [AddrW-1:0] paddr        = '0;
  logic [ApbW-1:0]  pwdata       = '0;
  wire  [ApbW-1:0]  prdata;
  wire              pready;

  int      fail_count;
  int      pending;
  bit      long_hold_req = 1'b0;
  bit      steady        = 1'b0;
  sample_t ramp_val      = '0;
  int      ramp_step     = 1;

  always #5 clk_i = ~clk_i;

  sliding_window_minimum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  swm_min_checker min_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of full-range values, tight clusters with ties, ramps and extremes
  function automatic sample_t next_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return sample_t'($urandom());
    if (roll < 65) return sample_t'($urandom_range(0, 8)) - 4;
    if (roll < 85) begin
      if ($urandom_range(0, 15) == 0) ramp_step = $urandom_range(0, 2000) - 1000;
      ramp_val += ramp_step;
      return ramp_val;
    end
    case ($urandom_range(0, 3))
      0:       return MaxSample;
      1:       return MinSample;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  // Offer one sample word, hold it until taken, then maybe idle
  task automatic send_sample(input sample_t value);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every predicted result word
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup then access phase, then back to idle
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [ApbW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, a long hold-off on request, none when steady
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        gap = steady ? 0 : pick_gap();
        m_axis_tready <= (gap == 0);
        repeat ((gap == 0) ? 1 : gap) @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin
    sample_t  extreme_vals [5]  = '{MaxSample, MinSample, 0, -1, 1};
    sample_t  zero_len_vals [3] = '{-3, 5, MinSample};
    sample_t  expiry_vals [13]  = '{10, 10, 10, 9, 12, 13, 14, 15, MinSample,
                                    MaxSample, MaxSample, MaxSample, MaxSample};
    win_len_t phase_len [NumPhases] = '{9'd2, 9'd256, 9'd3, 9'd511, 9'd8, 9'd1,
                                        9'd300, 9'd64, 9'd0, 9'd255, 9'd257, 9'd5};
    int       phase_items [NumPhases] = '{100, 330, 80, 300, 100, 60,
                                          120, 100, 60, 100, 100, 60};

    phase_len[NumPhases-1] = win_len_t'($urandom_range(1, 511));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window of one after reset: each result is its own sample
    foreach (extreme_vals[i]) send_sample(extreme_vals[i]);
    drain_results();

    // zero length acts as one
    write_reg(WinLenAddr, {23'($urandom()), 9'd0});
    foreach (zero_len_vals[i]) send_sample(zero_len_vals[i]);
    drain_results();

    // window of four: ties, then a minimum that expires
    write_reg(WinLenAddr, {23'($urandom()), 9'd4});
    foreach (expiry_vals[i]) send_sample(expiry_vals[i]);

    // random phases, window length changed between them without reset
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_reg(WinLenAddr, {23'($urandom()), phase_len[p]});
      // a write to the unused register must not touch the window length
      if (p == 5) write_reg(SpareRegAddr, {23'($urandom()), 9'd7});
      steady        = (p == 4 || p == 9);
      long_hold_req = (p == 1);
      for (int n = 0; n < phase_items[p]; n++) send_sample(next_sample());
    end
    drain_results();

    if (fail_count == 0) begin
      $display("sliding_window_minimum test passed");
    end else begin
      $display("sliding_window_minimum test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("sliding_window_minimum test failed");
    $finish;
  end

endmodule
